[sv/dsst_pkg.sv]
// Shared types and constants for the disc sector seek translator.
// Used by dsst_cell, dsst_tail and disc_sector_seek_translator_core.
// No dependencies.
`default_nettype none

package dsst_pkg;

    localparam int MAX_REGIONS = 16;

    localparam logic [10:0] RAW_WORDS  = 11'd1176;
    localparam logic [7:0]  XA_DISC    = 8'h20;
    localparam logic [7:0]  AUDIO_MODE = 8'h12;
    localparam logic [7:0]  EMPTY_TYPE = 8'hFF;

    localparam logic [1:0] OP_LOAD       = 2'd0;
    localparam logic [1:0] OP_DATA_SEEK  = 2'd1;
    localparam logic [1:0] OP_AUDIO_SEEK = 2'd2;

    localparam logic REG_REGION_COUNT = 1'b0;
    localparam logic REG_DISC_CODE    = 1'b1;

    // Read-mode select field, bits 3..1 of the mode byte.
    localparam logic [2:0] SEL_PLAIN    = 3'd0;
    localparam logic [2:0] SEL_AUDIO    = 3'd1;
    localparam logic [2:0] SEL_MODE1    = 3'd2;
    localparam logic [2:0] SEL_MODE2    = 3'd3;
    localparam logic [2:0] SEL_XA_FORM1 = 3'd4;
    localparam logic [2:0] SEL_XA_FORM2 = 3'd5;
    localparam logic [2:0] SEL_RAW      = 3'd6;
    localparam logic [2:0] SEL_BAD      = 3'd7;

    // Scan packet handed from cell to cell.
    typedef struct packed {
        logic        valid;
        logic [1:0]  op;
        logic [23:0] sector;
        logic [7:0]  mode;
        logic        hit;
        logic        stop;
        logic [23:0] start;
        logic [7:0]  rtype;
        logic [31:0] block;
    } t_scan;

    typedef struct packed {
        logic        ok;
        logic [31:0] file_block;
        logic [7:0]  word_offset;
        logic [7:0]  skip_before_words;
        logic [7:0]  skip_after_words;
        logic [10:0] payload_words;
        logic [7:0]  subcode_first;
        logic        toc_flag;
    } t_result;

endpackage

`default_nettype wire

[sv/disc_sector_seek_translator_core.sv]
// Top level of the disc sector seek translator: configuration registers,
// the region scan chain of dsst_cell, dsst_tail and the output register.
// Depends on dsst_pkg, dsst_cell and dsst_tail.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         i_in_valid / o_in_ready    i_opcode .. i_read_mode
//   result    out        o_out_valid / i_out_ready  o_ok .. o_toc_flag
//   config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Every item passes once down the chain of MAX_REGIONS cells, then through two
// tail stages, and lands in the output register when it leaves the second.
// One item is in flight at a time, so a new item is taken only after the result
// of the last has left the tail for the output register.
// A load writes its table cell at the input transfer. A stalled result holds
// the last tail stage and the input stays closed until the result moves on.
// Configuration writes are taken only while no item is in flight, and an
// offered write holds the input closed.
// Reset clears the configuration registers and the control state; table
// entries are undefined until loaded.
`default_nettype none

module disc_sector_seek_translator_core import dsst_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [3:0]  i_region_slot,
    input  logic [23:0] i_region_start,
    input  logic [7:0]  i_region_type,
    input  logic [31:0] i_region_file_block,
    input  logic [23:0] i_sector,
    input  logic [7:0]  i_read_mode,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_ok,
    output logic [31:0] o_file_block,
    output logic [7:0]  o_word_offset,
    output logic [7:0]  o_skip_before_words,
    output logic [7:0]  o_skip_after_words,
    output logic [10:0] o_payload_words,
    output logic [7:0]  o_subcode_first,
    output logic        o_toc_flag,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic [4:0]  r_region_count;
    logic [7:0]  r_disc_code;
    logic        r_busy;
    logic        r_out_valid;
    t_result     r_out;

    logic        in_xfer;
    logic        cfg_xfer;
    logic        take;
    logic        tail_valid;
    t_result     tail_res;
    t_scan       scan_link [MAX_REGIONS+1];
    logic [MAX_REGIONS-1:0] chain_valid;

    assign in_xfer     = i_in_valid && o_in_ready;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;
    assign o_in_ready  = !r_busy && !i_cfg_valid;
    assign o_cfg_ready = !r_busy;
    assign take        = !r_out_valid || i_out_ready;

    always_comb begin
        scan_link[0].valid  = in_xfer;
        scan_link[0].op     = i_opcode;
        scan_link[0].sector = i_sector;
        scan_link[0].mode   = i_read_mode;
        scan_link[0].hit    = 1'b0;
        scan_link[0].stop   = 1'b0;
        scan_link[0].start  = i_sector;
        scan_link[0].rtype  = EMPTY_TYPE;
        scan_link[0].block  = '0;
    end

    for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
        logic wr_sel;
        logic active;

        assign wr_sel = in_xfer && (i_opcode == OP_LOAD) && (32'(i_region_slot) == g);
        assign active = 32'(r_region_count) > g;
        assign chain_valid[g] = scan_link[g+1].valid;

        dsst_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_wr       (wr_sel),
            .i_wr_start (i_region_start),
            .i_wr_type  (i_region_type),
            .i_wr_block (i_region_file_block),
            .i_active   (active),
            .i_scan     (scan_link[g]),
            .o_scan     (scan_link[g+1])
        );
    end

    dsst_tail u_tail (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_scan  (scan_link[MAX_REGIONS]),
        .i_xa    (r_disc_code == XA_DISC),
        .i_empty (r_region_count == '0),
        .i_take  (take),
        .o_valid (tail_valid),
        .o_res   (tail_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_count <= '0;
            r_disc_code    <= '0;
            r_busy         <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (cfg_xfer) begin
                unique case (i_cfg_index)
                    REG_REGION_COUNT: r_region_count <= i_cfg_data[4:0];
                    REG_DISC_CODE:    r_disc_code    <= i_cfg_data;
                    default:          r_disc_code    <= r_disc_code;
                endcase
            end
            if (in_xfer) begin
                r_busy <= 1'b1;
            end else if (tail_valid && take) begin
                r_busy <= 1'b0;
            end
            if (tail_valid && take) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tail_valid && take) begin
            r_out <= tail_res;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_ok                = r_out.ok;
    assign o_file_block        = r_out.file_block;
    assign o_word_offset       = r_out.word_offset;
    assign o_skip_before_words = r_out.skip_before_words;
    assign o_skip_after_words  = r_out.skip_after_words;
    assign o_payload_words     = r_out.payload_words;
    assign o_subcode_first     = r_out.subcode_first;
    assign o_toc_flag          = r_out.toc_flag;

    a_one_in_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(chain_valid))
        else $error("More than one item travels the scan chain.");

    a_tail_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tail_valid |-> r_busy)
        else $error("The tail holds a result with no item in flight.");

    a_result_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_busy))
        else $error("A result appeared with no item in flight.");

    a_chain_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (chain_valid == '0) && !tail_valid)
        else $error("The scan chain is active while the block is idle.");

endmodule

`default_nettype wire

[sv/dsst_cell.sv]
// One cell of the region scan chain: holds one region table entry and
// one stage of the scan packet. Depends on dsst_pkg.
`default_nettype none

module dsst_cell import dsst_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr,
    input  logic [23:0] i_wr_start,
    input  logic [7:0]  i_wr_type,
    input  logic [31:0] i_wr_block,
    input  logic        i_active,
    input  t_scan       i_scan,
    output t_scan       o_scan
);

    logic [23:0] r_start;
    logic [7:0]  r_type;
    logic [31:0] r_block;
    t_scan       r_scan;
    t_scan       n_scan;
    logic        is_seek;

    assign is_seek = (i_scan.op == OP_DATA_SEEK) || (i_scan.op == OP_AUDIO_SEEK);

    always_comb begin
        n_scan = i_scan;
        if (i_scan.valid && is_seek && i_active && !i_scan.stop) begin
            if (i_scan.sector >= r_start) begin
                n_scan.hit   = 1'b1;
                n_scan.start = r_start;
                n_scan.rtype = r_type;
                n_scan.block = r_block;
            end else begin
                n_scan.stop = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_start <= i_wr_start;
            r_type  <= i_wr_type;
            r_block <= i_wr_block;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else begin
            r_scan <= n_scan;
        end
    end

    assign o_scan = r_scan;

endmodule

`default_nettype wire

[sv/dsst_tail.sv]
// Translation stages after the scan chain: read-mode decode, the
// offset multiply and the final block and word arithmetic. Depends on dsst_pkg.
`default_nettype none

module dsst_tail import dsst_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_scan   i_scan,
    input  logic    i_xa,
    input  logic    i_empty,
    input  logic    i_take,
    output logic    o_valid,
    output t_result o_res
);

    localparam logic [7:0] SKIP_ECC_XA   = 8'd140;
    localparam logic [7:0] SKIP_ECC      = 8'd144;
    localparam logic [7:0] SKIP_EDC_XA   = 8'd2;
    localparam logic [7:0] SKIP_SUBHDR   = 8'd4;
    localparam logic [7:0] SKIP_SYNC_HDR = 8'd8;

    logic [7:0]  mode;
    logic [2:0]  sel;
    logic        dec_fail;
    logic [7:0]  dec_sb;
    logic [7:0]  dec_sa;

    logic        r_s1_valid;
    logic [1:0]  r_s1_op;
    logic [23:0] r_s1_diff;
    logic        r_s1_fail;
    logic [7:0]  r_s1_sb;
    logic [7:0]  r_s1_sa;
    logic [7:0]  r_s1_rtype;
    logic [31:0] r_s1_block;

    logic        r_s2_valid;
    logic [1:0]  r_s2_op;
    logic [31:0] r_s2_w;
    logic        r_s2_fail;
    logic [7:0]  r_s2_sb;
    logic [7:0]  r_s2_sa;
    logic [7:0]  r_s2_rtype;
    logic [31:0] r_s2_block;

    logic [31:0] prod;
    logic [8:0]  sum;
    logic        carry;
    logic [31:0] seek_blk;

    assign mode = (i_scan.op == OP_AUDIO_SEEK) ? AUDIO_MODE : i_scan.mode;
    assign sel  = mode[3:1];

    always_comb begin
        dec_fail = 1'b0;
        dec_sb   = '0;
        dec_sa   = '0;
        unique case (sel)
            SEL_PLAIN: begin
                if (!mode[4]) begin
                    if (!i_scan.rtype[2]) begin
                        dec_fail = 1'b1;
                    end else if (i_xa) begin
                        dec_sa = SKIP_ECC_XA;
                        if (!mode[6]) begin
                            dec_sb = SKIP_SUBHDR;
                        end
                    end else begin
                        dec_sa = SKIP_ECC;
                    end
                end
            end
            SEL_AUDIO: begin
                if (i_scan.rtype[2]) begin
                    dec_fail = 1'b1;
                end
            end
            SEL_MODE1, SEL_MODE2: begin
                if (sel == SEL_MODE1) begin
                    dec_sa = SKIP_ECC;
                end
                if (!i_scan.rtype[2] || i_xa) begin
                    dec_fail = 1'b1;
                end
            end
            SEL_XA_FORM1, SEL_XA_FORM2: begin
                dec_sa = (sel == SEL_XA_FORM1) ? SKIP_ECC_XA : SKIP_EDC_XA;
                if (!i_scan.rtype[2] || !i_xa) begin
                    dec_fail = 1'b1;
                end
                if (!mode[6]) begin
                    dec_sb = SKIP_SUBHDR;
                end
            end
            SEL_RAW: begin
                dec_fail = 1'b0;
            end
            SEL_BAD: begin
                dec_fail = 1'b1;
            end
            default: begin
                dec_fail = 1'b1;
            end
        endcase
        if (mode[4]) begin
            dec_sb = '0;
            dec_sa = '0;
        end else if (!mode[5]) begin
            dec_fail = 1'b1;
        end else if (!mode[7]) begin
            dec_sb = dec_sb + SKIP_SYNC_HDR;
        end
        if (!i_scan.hit && !i_empty) begin
            dec_fail = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_scan.valid;
            if (r_s1_valid) begin
                r_s2_valid <= 1'b1;
            end else if (i_take) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_op    <= i_scan.op;
        r_s1_diff  <= i_scan.sector - i_scan.start;
        r_s1_fail  <= dec_fail;
        r_s1_sb    <= dec_sb;
        r_s1_sa    <= dec_sa;
        r_s1_rtype <= i_scan.rtype;
        r_s1_block <= i_scan.block;
        if (r_s1_valid) begin
            r_s2_op    <= r_s1_op;
            r_s2_w     <= prod;
            r_s2_fail  <= r_s1_fail;
            r_s2_sb    <= r_s1_sb;
            r_s2_sa    <= r_s1_sa;
            r_s2_rtype <= r_s1_rtype;
            r_s2_block <= r_s1_block;
        end
    end

    assign prod     = 32'(r_s1_diff) * 32'(RAW_WORDS);
    assign sum      = 9'(r_s2_w[7:0]) + 9'(r_s2_sb);
    assign carry    = (r_s2_op == OP_DATA_SEEK) && sum[8];
    assign seek_blk = (r_s2_w >> 8) + r_s2_block + 32'(carry);

    always_comb begin
        o_res = '0;
        case (r_s2_op)
            OP_LOAD: begin
                o_res.ok = 1'b1;
            end
            OP_DATA_SEEK, OP_AUDIO_SEEK: begin
                if (!r_s2_fail) begin
                    o_res.ok                = 1'b1;
                    o_res.file_block        = seek_blk;
                    o_res.skip_before_words = r_s2_sb;
                    o_res.skip_after_words  = r_s2_sa;
                    o_res.payload_words     = RAW_WORDS - 11'(r_s2_sb) - 11'(r_s2_sa);
                    if (r_s2_op == OP_DATA_SEEK) begin
                        o_res.word_offset = sum[7:0];
                    end else begin
                        o_res.subcode_first = {r_s2_rtype[3:0], 4'b0001};
                        o_res.toc_flag      = r_s2_rtype[7];
                    end
                end
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

    assign o_valid = r_s2_valid;

endmodule

`default_nettype wire
